// ===== rtl/core/smsdf_pkg.sv =====
// Shared types and constants for the SMS RP-DATA deframer.
// Holds the command word passed from the parser to the emitter and the field widths.
// No dependencies.
`default_nettype none

package smsdf_pkg;

   localparam int unsigned MAX_ADDR_LEN_DEF = 16;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned LEN_W            = 10;
   localparam int unsigned CAP_W            = 10;
   localparam int unsigned QUEUE_DEPTH      = 4;

   localparam logic [CAP_W-1:0]  CAP_RESET    = 10'd1023;
   localparam logic [LEN_W-1:0]  POS_MAX      = 10'd1023;
   localparam logic [LEN_W-1:0]  MIN_MSG_LEN  = 10'd3;
   localparam logic [BYTE_W-1:0] TYPE_MASK    = 8'h07;
   localparam logic [BYTE_W-1:0] TYPE_RP_DATA = 8'h01;
   localparam logic [BYTE_W-1:0] UDL_TAG      = 8'h41;

   typedef enum logic [1:0] {
      CMD_BYTE     = 2'd0,  // one data word, last flag as given
      CMD_ERR      = 2'd1,  // one rejection word
      CMD_BURST    = 2'd2,  // address length, then the buffered address
      CMD_BYTE_ERR = 2'd3   // data word followed by a rejection word
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [BYTE_W-1:0] msg_ref;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] idx;
      logic [BYTE_W-1:0] data;
   } addr_wr_type;

   typedef struct packed {
      logic q_full;
      logic q_empty;
      logic burst_busy;
   } drain_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/smsdf_queue.sv =====
// Command queue between the parser and the emitter.
// Small register FIFO of smsdf_pkg::cmd_type words; uses smsdf_pkg.
`default_nettype none

module smsdf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire smsdf_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output smsdf_pkg::cmd_type     head,
   output logic                   full,
   output logic                   empty
);
   import smsdf_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/smsdf_parse.sv =====
// Front end: accepts message words, walks the RP-DATA header and issues commands.
// Writes the originator address into the emitter's buffer; uses smsdf_pkg.
`default_nettype none

module smsdf_parse #(
   parameter int unsigned MAX_ADDR_LEN = smsdf_pkg::MAX_ADDR_LEN_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [smsdf_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic [smsdf_pkg::LEN_W-1:0]  req_msg_len,
   input  wire logic                         req_last_byte,
   input  wire logic [smsdf_pkg::CAP_W-1:0]  capacity,
   input  wire smsdf_pkg::drain_stat_type    drain,
   output logic                              cmd_push,
   output smsdf_pkg::cmd_type                cmd,
   output smsdf_pkg::addr_wr_type            addr_wr
);
   import smsdf_pkg::*;

   typedef enum logic [7:0] {
      PH_TYPE    = 8'b0000_0001,
      PH_REF     = 8'b0000_0010,
      PH_OA_LEN  = 8'b0000_0100,
      PH_OA_BODY = 8'b0000_1000,
      PH_DA_LEN  = 8'b0001_0000,
      PH_DA_SKIP = 8'b0010_0000,
      PH_UDL     = 8'b0100_0000,
      PH_PAYLOAD = 8'b1000_0000
   } phase_type;

   localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_ADDR_LEN);

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] skip_ff, skip_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0] addr_len_ff, addr_len_in;
   logic [BYTE_W-1:0] ref_ff, ref_in;
   logic              rej_ff, rej_in;

   logic              accept;
   logic              fail;
   logic              byte_pushed;
   logic              end_msg;
   logic [LEN_W:0]    len_x;
   logic [LEN_W:0]    pos_p1;
   logic [LEN_W:0]    field_end;
   logic [LEN_W:0]    out_total;
   logic [BYTE_W:0]   skip_p1;

   // Buffer writes must not overtake a burst of the previous message still being read.
   assign req_stall = drain.q_full ||
                      (phase_ff == PH_OA_BODY && !rej_ff &&
                       (!drain.q_empty || drain.burst_busy));
   assign accept    = req_valid && !req_stall;

   assign len_x     = {1'b0, req_msg_len};
   assign pos_p1    = {1'b0, pos_ff} + (LEN_W+1)'(1);
   assign field_end = pos_p1 + {3'b000, req_data_byte};
   assign out_total = (LEN_W+1)'(1) + {3'b000, addr_len_ff} + {3'b000, req_data_byte};
   assign skip_p1   = {1'b0, skip_ff} + (BYTE_W+1)'(1);

   assign addr_wr.en   = accept && !rej_ff && phase_ff == PH_OA_BODY;
   assign addr_wr.idx  = skip_ff;
   assign addr_wr.data = req_data_byte;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      skip_in     = skip_ff;
      rem_in      = rem_ff;
      addr_len_in = addr_len_ff;
      ref_in      = ref_ff;
      rej_in      = rej_ff;
      fail        = 1'b0;
      byte_pushed = 1'b0;
      end_msg     = 1'b0;
      cmd_push    = 1'b0;
      cmd.kind    = CMD_BYTE;
      cmd.data    = '0;
      cmd.last    = 1'b0;
      cmd.msg_ref = ref_ff;

      if (accept) begin
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
         if (rej_ff) begin
            end_msg = req_last_byte;
         end else begin
            unique case (phase_ff)
               PH_TYPE: begin
                  ref_in = '0;
                  if (req_msg_len < MIN_MSG_LEN ||
                      (req_data_byte & TYPE_MASK) != TYPE_RP_DATA) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_REF;
                  end
               end
               PH_REF: begin
                  ref_in   = req_data_byte;
                  phase_in = PH_OA_LEN;
               end
               PH_OA_LEN: begin
                  if (req_data_byte > MAX_LEN_B || field_end >= len_x) begin
                     fail = 1'b1;
                  end else begin
                     addr_len_in = req_data_byte;
                     skip_in     = '0;
                     phase_in    = (req_data_byte != '0) ? PH_OA_BODY : PH_DA_LEN;
                  end
               end
               PH_OA_BODY: begin
                  skip_in = skip_p1[BYTE_W-1:0];
                  if (skip_p1 >= {1'b0, addr_len_ff}) begin
                     phase_in = PH_DA_LEN;
                  end
               end
               PH_DA_LEN: begin
                  if (field_end >= len_x) begin
                     fail = 1'b1;
                  end else if (req_data_byte != '0) begin
                     skip_in  = req_data_byte;
                     phase_in = PH_DA_SKIP;
                  end else begin
                     skip_in  = BYTE_W'(1);
                     phase_in = PH_UDL;
                  end
               end
               PH_DA_SKIP: begin
                  if (skip_ff <= BYTE_W'(1)) begin
                     skip_in  = BYTE_W'(1);
                     phase_in = PH_UDL;
                  end else begin
                     skip_in = skip_ff - 1'b1;
                  end
               end
               PH_UDL: begin
                  // optional tag ahead of the user-data length, taken only once
                  if (skip_ff == BYTE_W'(1) && req_data_byte == UDL_TAG && pos_p1 < len_x) begin
                     skip_in = '0;
                  end else if (req_last_byte || req_data_byte == '0 ||
                               field_end > len_x ||
                               out_total > {1'b0, capacity}) begin
                     fail = 1'b1;
                  end else begin
                     cmd_push    = 1'b1;
                     cmd.kind    = CMD_BURST;
                     cmd.data    = addr_len_ff;
                     rem_in      = req_data_byte;
                     phase_in    = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (rem_ff != '0) begin
                     rem_in      = rem_ff - 1'b1;
                     cmd_push    = 1'b1;
                     byte_pushed = 1'b1;
                     cmd.kind    = CMD_BYTE;
                     cmd.data    = req_data_byte;
                     cmd.last    = (rem_ff == BYTE_W'(1));
                  end
               end
               default: begin
                  phase_in = PH_TYPE;
               end
            endcase

            cmd.msg_ref = ref_in;
            if (fail) begin
               cmd_push = 1'b1;
               cmd.kind = CMD_ERR;
               cmd.data = '0;
               cmd.last = 1'b1;
               if (req_last_byte) begin
                  end_msg = 1'b1;
               end else begin
                  rej_in = 1'b1;
               end
            end else if (req_last_byte) begin
               // early end: payload not complete
               if (!(phase_in == PH_PAYLOAD && rem_in == '0)) begin
                  cmd_push = 1'b1;
                  cmd.last = 1'b0;
                  if (byte_pushed) begin
                     cmd.kind = CMD_BYTE_ERR;
                  end else begin
                     cmd.kind = CMD_ERR;
                     cmd.data = '0;
                  end
               end
               end_msg = 1'b1;
            end
         end

         if (end_msg) begin
            phase_in    = PH_TYPE;
            pos_in      = '0;
            skip_in     = '0;
            rem_in      = '0;
            addr_len_in = '0;
            rej_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         pos_ff      <= '0;
         skip_ff     <= '0;
         rem_ff      <= '0;
         addr_len_ff <= '0;
         ref_ff      <= '0;
         rej_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         rem_ff      <= rem_in;
         addr_len_ff <= addr_len_in;
         ref_ff      <= ref_in;
         rej_ff      <= rej_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/smsdf_emit.sv =====
// Back end: drains the command queue into the registered result channel.
// Owns the originator address buffer and replays it on a burst; uses smsdf_pkg.
`default_nettype none

module smsdf_emit #(
   parameter int unsigned MAX_ADDR_LEN = smsdf_pkg::MAX_ADDR_LEN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire smsdf_pkg::addr_wr_type        addr_wr,
   input  wire smsdf_pkg::cmd_type            head,
   input  wire logic                          q_empty,
   output logic                               pop,
   output logic                               burst_busy,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [smsdf_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                               rsp_status,
   output logic                               rsp_is_last,
   output logic [smsdf_pkg::BYTE_W-1:0]       rsp_message_ref
);
   import smsdf_pkg::*;

   localparam int unsigned IDX_W = (MAX_ADDR_LEN > 1) ? $clog2(MAX_ADDR_LEN) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BURST = 3'b010,
      ST_ERR   = 3'b100
   } emit_state_type;

   logic [BYTE_W-1:0] addr_mem [MAX_ADDR_LEN];

   emit_state_type    state_ff, state_in;
   logic [BYTE_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] sref_ff, sref_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_status_ff;
   logic              rsp_last_ff;
   logic [BYTE_W-1:0] rsp_ref_ff;

   logic              load;
   logic              out_load;
   logic              sel_mem;
   logic [IDX_W-1:0]  rd_idx;
   logic [BYTE_W-1:0] byte_in;
   logic              status_in;
   logic              last_in;
   logic [BYTE_W-1:0] ref_in;
   logic [BYTE_W:0]   cnt_p1;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign burst_busy = (state_ff == ST_BURST);
   assign cnt_p1     = {1'b0, cnt_ff} + (BYTE_W+1)'(1);
   assign rd_idx     = cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      sref_in      = sref_ff;
      pop          = 1'b0;
      out_load     = 1'b0;
      sel_mem      = 1'b0;
      byte_in      = '0;
      status_in    = 1'b0;
      last_in      = 1'b0;
      ref_in       = sref_ff;
      rsp_valid_in = rsp_valid_ff;

      if (load) begin
         rsp_valid_in = 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  pop          = 1'b1;
                  out_load     = 1'b1;
                  rsp_valid_in = 1'b1;
                  ref_in       = head.msg_ref;
                  sref_in      = head.msg_ref;
                  case (head.kind)
                     CMD_BYTE: begin
                        byte_in = head.data;
                        last_in = head.last;
                     end
                     CMD_ERR: begin
                        status_in = 1'b1;
                        last_in   = 1'b1;
                     end
                     CMD_BURST: begin
                        byte_in = head.data;
                        if (head.data != '0) begin
                           cnt_in   = '0;
                           len_in   = head.data;
                           state_in = ST_BURST;
                        end
                     end
                     default: begin
                        byte_in  = head.data;
                        state_in = ST_ERR;
                     end
                  endcase
               end
            end
            ST_BURST: begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               sel_mem      = 1'b1;
               cnt_in       = cnt_p1[BYTE_W-1:0];
               if (cnt_p1 == {1'b0, len_ff}) begin
                  state_in = ST_IDLE;
               end
            end
            ST_ERR: begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = 1'b1;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         len_ff       <= '0;
         sref_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         sref_ff      <= sref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (addr_wr.en) begin
         addr_mem[addr_wr.idx[IDX_W-1:0]] <= addr_wr.data;
      end
   end

   // result word register; the address buffer is read straight into it
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_byte_ff   <= sel_mem ? addr_mem[rd_idx] : byte_in;
         rsp_status_ff <= status_in;
         rsp_last_ff   <= last_in;
         rsp_ref_ff    <= ref_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_is_last     = rsp_last_ff;
   assign rsp_message_ref = rsp_ref_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sms_rp_data_deframer_unit.sv =====
// SMS RP-DATA deframer top level: parser, command queue, emitter, capacity register.
// A result word passes through the command queue and then the registered result channel.
// Throughput: one input byte per cycle unless stalled; an accepted user-data length
// byte makes 1 + address length output words, set by the single address buffer read port.
// Originator address bytes stall while an earlier address burst is still draining.
// Reset: synchronous, active high; clears all control state, capacity returns to 1023.
`default_nettype none

module sms_rp_data_deframer_unit #(
   parameter int unsigned MAX_ADDR_LEN = smsdf_pkg::MAX_ADDR_LEN_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [smsdf_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic [smsdf_pkg::LEN_W-1:0]  req_msg_len,
   input  wire logic                         req_last_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [smsdf_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                              rsp_status,
   output logic                              rsp_is_last,
   output logic [smsdf_pkg::BYTE_W-1:0]      rsp_message_ref,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [smsdf_pkg::CAP_W-1:0]  csr_output_capacity
);
   import smsdf_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             cmd_push;
   cmd_type          cmd;
   cmd_type          head;
   addr_wr_type      addr_wr;
   drain_stat_type   drain;
   logic             q_full;
   logic             q_empty;
   logic             pop;
   logic             burst_busy;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_output_capacity : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign drain.q_full     = q_full;
   assign drain.q_empty    = q_empty;
   assign drain.burst_busy = burst_busy;

   smsdf_parse #(
      .MAX_ADDR_LEN (MAX_ADDR_LEN)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_msg_len   (req_msg_len),
      .req_last_byte (req_last_byte),
      .capacity      (cap_ff),
      .drain         (drain),
      .cmd_push      (cmd_push),
      .cmd           (cmd),
      .addr_wr       (addr_wr)
   );

   smsdf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   smsdf_emit #(
      .MAX_ADDR_LEN (MAX_ADDR_LEN)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .addr_wr         (addr_wr),
      .head            (head),
      .q_empty         (q_empty),
      .pop             (pop),
      .burst_busy      (burst_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_is_last     (rsp_is_last),
      .rsp_message_ref (rsp_message_ref)
   );

endmodule

`default_nettype wire

// ===== sim/sms_rp_data_deframer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the SMS RP-DATA deframer: follows the byte, result and capacity channels,
// predicts the result words of every accepted byte and compares them in arrival order.
// Depends on smsdf_pkg for widths and protocol constants.
module sms_rp_data_deframer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [smsdf_pkg::BYTE_W-1:0] req_data_byte,
   input  logic [smsdf_pkg::LEN_W-1:0]  req_msg_len,
   input  logic                         req_last_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [smsdf_pkg::BYTE_W-1:0] rsp_out_byte,
   input  logic                         rsp_status,
   input  logic                         rsp_is_last,
   input  logic [smsdf_pkg::BYTE_W-1:0] rsp_message_ref,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [smsdf_pkg::CAP_W-1:0]  csr_output_capacity,
   output int                           pending_words,
   output int                           fail_count
);
   import smsdf_pkg::*;

   localparam int ADDR_MAX = MAX_ADDR_LEN_DEF;

   typedef enum logic [2:0] {
      AWAIT_TYPE, AWAIT_REF, AWAIT_OA_LEN, IN_OA_BODY,
      AWAIT_DA_LEN, IN_DA_SKIP, AWAIT_UDL, IN_PAYLOAD
   } parse_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              status;
      logic              is_last;
      logic [BYTE_W-1:0] msg_ref;
   } deframe_word_type;

   deframe_word_type  pdu_q[$];
   parse_state_type   state;
   logic [BYTE_W-1:0] oa_buf[ADDR_MAX];
   logic [BYTE_W-1:0] ref_byte;
   int                position;
   int                oa_len;
   int                count;
   int                pay_left;
   int                capacity;
   bit                dropping;
   int                mismatches;

   function automatic void clear_message();
      state    = AWAIT_TYPE;
      position = 0;
      count    = 0;
      pay_left = 0;
      oa_len   = 0;
      dropping = 1'b0;
   endfunction

   function automatic void emit_word(input logic [BYTE_W-1:0] b, input logic st,
                                     input logic lst);
      deframe_word_type w;
      w.out_byte = b;
      w.status   = st;
      w.is_last  = lst;
      w.msg_ref  = ref_byte;
      pdu_q.push_back(w);
   endfunction

   function automatic void predict_deframe(input logic [BYTE_W-1:0] b,
                                           input logic [LEN_W-1:0] len, input logic lst);
      int               p;
      int               n;
      bit               fail;
      deframe_word_type tail;
      p    = position;
      n    = 0;
      fail = 1'b0;
      if (position < int'(POS_MAX)) position++;
      if (dropping) begin
         if (lst) clear_message();
         return;
      end
      case (state)
         AWAIT_TYPE: begin
            ref_byte = '0;
            if (len < MIN_MSG_LEN || (b & TYPE_MASK) != TYPE_RP_DATA) fail = 1'b1;
            else state = AWAIT_REF;
         end
         AWAIT_REF: begin
            ref_byte = b;
            state    = AWAIT_OA_LEN;
         end
         AWAIT_OA_LEN: begin
            if (int'(b) > ADDR_MAX || p + 1 + int'(b) >= int'(len)) begin
               fail = 1'b1;
            end else begin
               oa_len = b;
               count  = 0;
               state  = (b != 0) ? IN_OA_BODY : AWAIT_DA_LEN;
            end
         end
         IN_OA_BODY: begin
            if (count < ADDR_MAX) oa_buf[count] = b;
            count++;
            if (count >= oa_len) state = AWAIT_DA_LEN;
         end
         AWAIT_DA_LEN: begin
            if (p + 1 + int'(b) >= int'(len)) begin
               fail = 1'b1;
            end else if (b != 0) begin
               count = b;
               state = IN_DA_SKIP;
            end else begin
               count = 1;
               state = AWAIT_UDL;
            end
         end
         IN_DA_SKIP: begin
            if (count > 0) count--;
            if (count == 0) begin
               count = 1;
               state = AWAIT_UDL;
            end
         end
         AWAIT_UDL: begin
            // optional tag is only taken as the first byte after the destination address
            if (count == 1 && b == UDL_TAG && p + 1 < int'(len)) begin
               count = 0;
            end else if (lst || b == 0 || p + 1 + int'(b) > int'(len) ||
                         1 + oa_len + int'(b) > capacity) begin
               fail = 1'b1;
            end else begin
               emit_word(BYTE_W'(oa_len), 1'b0, 1'b0);
               for (int i = 0; i < oa_len && i < ADDR_MAX; i++)
                  emit_word(oa_buf[i], 1'b0, 1'b0);
               n        = 1 + oa_len;
               pay_left = b;
               state    = IN_PAYLOAD;
            end
         end
         default: begin
            if (pay_left > 0) begin
               pay_left--;
               emit_word(b, 1'b0, pay_left == 0);
               n = 1;
            end
         end
      endcase
      if (fail) begin
         emit_word('0, 1'b1, 1'b1);
         if (lst) clear_message();
         else dropping = 1'b1;
         return;
      end
      if (lst) begin
         // early end: the rejection word takes over the last flag
         if (!(state == IN_PAYLOAD && pay_left == 0)) begin
            if (n > 0) begin
               tail = pdu_q.pop_back();
               tail.is_last = 1'b0;
               pdu_q.push_back(tail);
            end
            emit_word('0, 1'b1, 1'b1);
         end
         clear_message();
      end
   endfunction

   always @(posedge clock) begin
      deframe_word_type got;
      deframe_word_type want;
      if (reset) begin
         pdu_q.delete();
         clear_message();
         ref_byte   = '0;
         capacity   = int'(CAP_RESET);
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_status, rsp_is_last, rsp_message_ref};
            if (pdu_q.size() == 0) begin
               $display("%0t: unexpected word, expected none actual %h/%b/%b/%h", $time,
                        got.out_byte, got.status, got.is_last, got.msg_ref);
               mismatches++;
            end else begin
               want = pdu_q.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h", $time,
                           want.out_byte, got.out_byte);
                  mismatches++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %b actual %b", $time,
                           want.status, got.status);
                  mismatches++;
               end
               if (got.is_last !== want.is_last) begin
                  $display("%0t: is_last expected %b actual %b", $time,
                           want.is_last, got.is_last);
                  mismatches++;
               end
               if (got.msg_ref !== want.msg_ref) begin
                  $display("%0t: message_ref expected %h actual %h", $time,
                           want.msg_ref, got.msg_ref);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) capacity = csr_output_capacity;
         if (req_valid && !req_stall) predict_deframe(req_data_byte, req_msg_len, req_last_byte);
      end
      pending_words <= pdu_q.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== sim/tb_sms_rp_data_deframer_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for sms_rp_data_deframer_unit: builds RP-DATA byte streams, drives
// the byte and capacity channels and gives the verdict. Depends on smsdf_pkg,
// the deframer RTL and sms_rp_data_deframer_checker.
module tb_sms_rp_data_deframer_unit;
   import smsdf_pkg::*;

   localparam int LIMIT = 400000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte;
   logic [LEN_W-1:0]  req_msg_len;
   logic              req_last_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_status;
   logic              rsp_is_last;
   logic [BYTE_W-1:0] rsp_message_ref;
   logic              csr_valid;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_output_capacity;
   int                pending_words;
   int                fail_count;

   int                idle_pct;
   int                stall_pct;
   int                cycles = 0;
   int                words_sent;
   logic [BYTE_W-1:0] msg_bytes[$];
   int                msg_length;
   int                idle_tab[5]   = '{0, 61, 0, 31, 31};
   int                stall_tab[5]  = '{0, 0, 61, 31, 31};
   int                budget_tab[5] = '{18, 18, 18, 18, 10};

   sms_rp_data_deframer_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_msg_len         (req_msg_len),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_status          (rsp_status),
      .rsp_is_last         (rsp_is_last),
      .rsp_message_ref     (rsp_message_ref),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_output_capacity (csr_output_capacity)
   );

   sms_rp_data_deframer_checker deframe_chk (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_msg_len         (req_msg_len),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_status          (rsp_status),
      .rsp_is_last         (rsp_is_last),
      .rsp_message_ref     (rsp_message_ref),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_output_capacity (csr_output_capacity),
      .pending_words       (pending_words),
      .fail_count          (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_word(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len,
                            input logic lst);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_msg_len   <= len;
      req_last_byte <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid, wait for every predicted word, then let the pipeline go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(negedge clock);
      csr_valid           <= 1'b1;
      csr_output_capacity <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void build_frame(input int oa_n, input int da_n, input bit tag,
                                       input int udl, input int pay_n, input int trail_n);
      msg_bytes.delete();
      msg_bytes.push_back(BYTE_W'(($urandom_range(0, 31) << 3) | TYPE_RP_DATA));
      msg_bytes.push_back(BYTE_W'($urandom));
      msg_bytes.push_back(BYTE_W'(oa_n));
      repeat (oa_n) msg_bytes.push_back(BYTE_W'($urandom));
      msg_bytes.push_back(BYTE_W'(da_n));
      repeat (da_n) msg_bytes.push_back(BYTE_W'($urandom));
      if (tag) msg_bytes.push_back(UDL_TAG);
      msg_bytes.push_back(BYTE_W'(udl));
      repeat (pay_n) msg_bytes.push_back(BYTE_W'($urandom));
      repeat (trail_n) msg_bytes.push_back(BYTE_W'($urandom));
      msg_length = msg_bytes.size();
   endfunction

   // sends the first upto bytes, marking the last of them as the message end
   task automatic send_frame(input int upto);
      for (int i = 0; i < upto; i++) begin
         send_word(msg_bytes[i], LEN_W'(msg_length), i == upto - 1);
         words_sent++;
      end
   endtask

   task automatic send_random_frame();
      int kind;
      int oa_n;
      int da_n;
      int udl;
      int upto;
      kind = $urandom_range(0, 9);
      oa_n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 4);
      da_n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      udl  = $urandom_range(1, 8);
      build_frame(oa_n, da_n, $urandom_range(0, 1), udl, udl,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      upto = msg_bytes.size();
      case ($urandom_range(0, 2))
         0: ;
         1: msg_length += $urandom_range(0, 8);
         default: msg_length += $urandom_range(0, 1023 - msg_bytes.size());
      endcase
      // kinds 0..6 stay well formed
      if (kind == 7) msg_bytes[$urandom_range(0, upto - 1)] = BYTE_W'($urandom);
      else if (kind == 8) msg_length = $urandom_range(0, 1023);
      else if (kind == 9) upto = $urandom_range(1, upto);
      send_frame(upto);
   endtask

   initial begin
      logic [CAP_W-1:0] cap;
      req_valid           = 1'b0;
      req_data_byte       = '0;
      req_msg_len         = '0;
      req_last_byte       = 1'b0;
      rsp_stall           = 1'b0;
      csr_valid           = 1'b0;
      csr_output_capacity = '0;
      idle_pct            = 0;
      stall_pct           = 0;
      words_sent          = 0;
      reset               = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases under a tight capacity
      write_capacity(CAP_W'(5));
      build_frame(0, 0, 0, 1, 1, 0);      // too short
      msg_length = 2;
      send_frame(2);
      build_frame(0, 0, 0, 1, 1, 0);      // wrong type
      msg_bytes[0] = 8'hFE;
      send_frame(3);
      build_frame(0, 0, 0, 1, 1, 0);      // smallest good message
      msg_bytes[1] = 8'hFF;
      msg_bytes[5] = 8'h00;
      send_frame(6);
      build_frame(0, 0, 0, 1, 1, 0);      // address too long
      msg_bytes[2] = BYTE_W'(MAX_ADDR_LEN_DEF + 1);
      send_frame(4);
      build_frame(2, 0, 0, 1, 1, 0);      // address runs past the length
      msg_length = 5;
      send_frame(4);
      build_frame(0, 0, 1, 0, 0, 0);      // tag, then zero user-data length
      send_frame(msg_bytes.size());
      build_frame(2, 0, 0, 3, 3, 0);      // one over capacity
      send_frame(msg_bytes.size());
      build_frame(2, 0, 0, 2, 2, 0);      // exactly at capacity
      msg_bytes[8] = 8'hFF;
      send_frame(msg_bytes.size());
      build_frame(1, 1, 0, 3, 3, 0);      // ends inside the payload
      send_frame(8);
      build_frame(0, 0, 0, 2, 2, 0);      // ends on the user-data length
      send_frame(5);
      build_frame(0, 0, 0, 1, 1, 2);      // trailing bytes
      send_frame(msg_bytes.size());

      for (int ph = 0; ph < 5; ph++) begin
         settle();
         case (ph)
            0: cap = CAP_RESET;
            1: cap = CAP_W'($urandom_range(8, 40));
            2: cap = CAP_RESET;
            3: cap = CAP_W'($urandom_range(0, 1023));
            default: cap = '0;
         endcase
         write_capacity(cap);
         idle_pct   = idle_tab[ph];
         stall_pct  = stall_tab[ph];
         words_sent = 0;
         while (words_sent < budget_tab[ph]) send_random_frame();
      end

      settle();
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/smsdf_pkg.sv
rtl/core/smsdf_queue.sv
rtl/core/smsdf_parse.sv
rtl/core/smsdf_emit.sv
rtl/core/sms_rp_data_deframer_unit.sv
sim/sms_rp_data_deframer_checker.sv
sim/tb_sms_rp_data_deframer_unit.sv
